// File: hw/rtl/principal_name_splitter_unit_macros.svh
// Assertion macros used by the checker file of the principal name splitter.
// No dependencies; include by bare file name.
`ifndef PRINCIPAL_NAME_SPLITTER_UNIT_MACROS_SVH
`define PRINCIPAL_NAME_SPLITTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PNS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PNS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/pns_pkg.sv
// Shared types, codes and constants of the principal name splitter.
// No dependencies; imported by every module of the block.
package pns_pkg;

    localparam int COUNT_BITS = 8;
    localparam int LIM_BITS   = 8;
    localparam int LIM_W      = (COUNT_BITS > LIM_BITS) ? COUNT_BITS : LIM_BITS;
    localparam int COUNT_MAX  = (1 << COUNT_BITS) - 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_PERIOD    = 8'h2e;
    localparam logic [7:0] CH_AT        = 8'h40;

    localparam logic [LIM_BITS-1:0] NAME_LIMIT_RST     = 8'd39;
    localparam logic [LIM_BITS-1:0] INSTANCE_LIMIT_RST = 8'd39;
    localparam logic [LIM_BITS-1:0] REALM_LIMIT_RST    = 8'd39;
    localparam logic [LIM_BITS-1:0] RAW_LIMIT_RST      = 8'd120;

    typedef enum logic [1:0] {
        MODE_BYTE     = 2'd0,
        MODE_BYTE_END = 2'd1,
        MODE_END      = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        REG_NAME_LIMIT     = 2'd0,
        REG_INSTANCE_LIMIT = 2'd1,
        REG_REALM_LIMIT    = 2'd2,
        REG_RAW_LIMIT      = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        FLD_NAME  = 2'd0,
        FLD_INST  = 2'd1,
        FLD_REALM = 2'd2
    } field_t;

    typedef enum logic [1:0] {
        CLS_PLAIN  = 2'd0,
        CLS_ESCAPE = 2'd1,
        CLS_PERIOD = 2'd2,
        CLS_AT     = 2'd3
    } byte_class_t;

    // Classified request carried from the front to the back.
    typedef struct packed {
        logic        has_byte;
        logic        ends;
        byte_class_t cls;
        logic [7:0]  data;
    } pns_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } pns_qstat_t;

    typedef struct packed {
        logic [LIM_BITS-1:0] name_limit;
        logic [LIM_BITS-1:0] instance_limit;
        logic [LIM_BITS-1:0] realm_limit;
        logic [LIM_BITS-1:0] raw_limit;
    } pns_limits_t;

    // Cap a limit register at the largest count value.
    function automatic logic [COUNT_BITS-1:0] eff_limit(input logic [LIM_BITS-1:0] lim);
        logic [LIM_W-1:0] wide;
        wide = LIM_W'(lim);
        if (wide > LIM_W'(COUNT_MAX))
        begin
            wide = LIM_W'(COUNT_MAX);
        end
        return COUNT_BITS'(wide);
    endfunction

endpackage

// File: hw/rtl/pns_front.sv
// Front stage: accepts requests, classifies the byte and decodes the mode.
// Depends on pns_pkg; feeds pns_queue.
module pns_front
    import pns_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] mode,
    input  logic [7:0] in_byte,
    input  pns_qstat_t qstat,
    output logic       push,
    output pns_item_t  push_item
);

    logic      valid_reg;
    logic      valid_next;
    pns_item_t item_reg;
    pns_item_t item_next;
    logic      load;

    assign in_stall  = valid_reg && qstat.full;
    assign load      = in_valid && !in_stall;
    assign push      = valid_reg && !qstat.full;
    assign push_item = item_reg;

    always_comb
    begin
        item_next.has_byte = (mode == MODE_BYTE) || (mode == MODE_BYTE_END);
        item_next.ends     = (mode != MODE_BYTE);
        item_next.data     = in_byte;
        if (in_byte == CH_BACKSLASH)
        begin
            item_next.cls = CLS_ESCAPE;
        end
        else if (in_byte == CH_PERIOD)
        begin
            item_next.cls = CLS_PERIOD;
        end
        else if (in_byte == CH_AT)
        begin
            item_next.cls = CLS_AT;
        end
        else
        begin
            item_next.cls = CLS_PLAIN;
        end
        valid_next = load || (valid_reg && !push);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// File: hw/rtl/pns_queue.sv
// Short queue of classified requests between the front and the back.
// Depends on pns_pkg.
module pns_queue
    import pns_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  pns_item_t  push_item,
    input  logic       pop,
    output pns_item_t  pop_item,
    output pns_qstat_t qstat
);

    pns_item_t            mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QPTR_BITS:0]   count_reg;
    logic [QPTR_BITS:0]   count_next;

    assign qstat.full  = (count_reg == (QPTR_BITS + 1)'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign pop_item    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: hw/rtl/pns_back.sv
// Back stage: parser state, length checks and the registered result.
// Depends on pns_pkg; drains pns_queue.
module pns_back
    import pns_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pns_limits_t limits,
    input  pns_qstat_t  qstat,
    input  pns_item_t   pop_item,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        char_valid,
    output logic [1:0]  field_tag,
    output logic [7:0]  out_char,
    output logic        done_res,
    output logic        status,
    output logic        instance_present,
    output logic        realm_present
);

    logic                  esc_reg, esc_next;
    field_t                field_reg, field_next;
    logic [COUNT_BITS-1:0] name_cnt_reg, name_cnt_next;
    logic [COUNT_BITS-1:0] inst_cnt_reg, inst_cnt_next;
    logic [COUNT_BITS-1:0] realm_cnt_reg, realm_cnt_next;
    logic [COUNT_BITS-1:0] raw_cnt_reg, raw_cnt_next;
    logic                  err_reg, err_next;
    logic                  inst_seen_reg, inst_seen_next;
    logic                  realm_seen_reg, realm_seen_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  char_valid_reg, char_valid_next;
    logic [1:0]            field_tag_reg, field_tag_next;
    logic [7:0]            out_char_reg, out_char_next;
    logic                  done_reg, done_next;
    logic                  status_reg, status_next;
    logic                  inst_pres_reg, inst_pres_next;
    logic                  realm_pres_reg, realm_pres_next;

    logic                  do_emit;
    logic [COUNT_BITS-1:0] sel_cnt;
    logic [COUNT_BITS-1:0] sel_lim;

    assign pop              = !qstat.empty && (!out_valid_reg || !out_stall);
    assign out_valid        = out_valid_reg;
    assign char_valid       = char_valid_reg;
    assign field_tag        = field_tag_reg;
    assign out_char         = out_char_reg;
    assign done_res         = done_reg;
    assign status           = status_reg;
    assign instance_present = inst_pres_reg;
    assign realm_present    = realm_pres_reg;

    // Count and limit of the field that takes the next character.
    always_comb
    begin
        case (field_reg)
            FLD_NAME:
            begin
                sel_cnt = name_cnt_reg;
                sel_lim = eff_limit(limits.name_limit);
            end
            FLD_INST:
            begin
                sel_cnt = inst_cnt_reg;
                sel_lim = eff_limit(limits.instance_limit);
            end
            default:
            begin
                sel_cnt = realm_cnt_reg;
                sel_lim = eff_limit(limits.realm_limit);
            end
        endcase
    end

    always_comb
    begin
        esc_next        = esc_reg;
        field_next      = field_reg;
        name_cnt_next   = name_cnt_reg;
        inst_cnt_next   = inst_cnt_reg;
        realm_cnt_next  = realm_cnt_reg;
        raw_cnt_next    = raw_cnt_reg;
        err_next        = err_reg;
        inst_seen_next  = inst_seen_reg;
        realm_seen_next = realm_seen_reg;
        do_emit         = 1'b0;

        char_valid_next = 1'b0;
        field_tag_next  = '0;
        out_char_next   = '0;
        done_next       = 1'b0;
        status_next     = 1'b0;
        inst_pres_next  = 1'b0;
        realm_pres_next = 1'b0;
        out_valid_next  = out_valid_reg && out_stall;

        if (pop)
        begin
            out_valid_next = 1'b1;
            if (pop_item.has_byte && !err_reg)
            begin
                if (raw_cnt_reg >= eff_limit(limits.raw_limit))
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    raw_cnt_next = raw_cnt_reg + 1'b1;
                    if (esc_reg)
                    begin
                        esc_next = 1'b0;
                        do_emit  = 1'b1;
                    end
                    else
                    begin
                        case (pop_item.cls)
                            CLS_ESCAPE:
                            begin
                                esc_next = 1'b1;
                            end
                            CLS_PERIOD:
                            begin
                                if (field_reg == FLD_NAME)
                                begin
                                    if (name_cnt_reg == '0)
                                    begin
                                        err_next = 1'b1;
                                    end
                                    else
                                    begin
                                        field_next     = FLD_INST;
                                        inst_seen_next = 1'b1;
                                    end
                                end
                                else
                                begin
                                    do_emit = 1'b1;
                                end
                            end
                            CLS_AT:
                            begin
                                if (field_reg == FLD_NAME)
                                begin
                                    if (name_cnt_reg == '0)
                                    begin
                                        err_next = 1'b1;
                                    end
                                    else
                                    begin
                                        inst_seen_next  = 1'b1;
                                        realm_seen_next = 1'b1;
                                        field_next      = FLD_REALM;
                                    end
                                end
                                else if (field_reg == FLD_INST)
                                begin
                                    realm_seen_next = 1'b1;
                                    field_next      = FLD_REALM;
                                end
                                else
                                begin
                                    err_next = 1'b1;
                                end
                            end
                            default:
                            begin
                                do_emit = 1'b1;
                            end
                        endcase
                    end
                end
            end

            if (do_emit)
            begin
                if (sel_cnt >= sel_lim)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    char_valid_next = 1'b1;
                    out_char_next   = pop_item.data;
                    case (field_reg)
                        FLD_NAME:
                        begin
                            name_cnt_next  = name_cnt_reg + 1'b1;
                            field_tag_next = FLD_NAME;
                        end
                        FLD_INST:
                        begin
                            inst_cnt_next  = inst_cnt_reg + 1'b1;
                            field_tag_next = FLD_INST;
                        end
                        default:
                        begin
                            realm_cnt_next = realm_cnt_reg + 1'b1;
                            field_tag_next = FLD_REALM;
                        end
                    endcase
                end
            end

            // Report the string end, then return to the idle parse state.
            if (pop_item.ends)
            begin
                done_next       = 1'b1;
                status_next     = err_next;
                inst_pres_next  = inst_seen_next;
                realm_pres_next = realm_seen_next;
                esc_next        = 1'b0;
                field_next      = FLD_NAME;
                name_cnt_next   = '0;
                inst_cnt_next   = '0;
                realm_cnt_next  = '0;
                raw_cnt_next    = '0;
                err_next        = 1'b0;
                inst_seen_next  = 1'b0;
                realm_seen_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg        <= 1'b0;
            field_reg      <= FLD_NAME;
            name_cnt_reg   <= '0;
            inst_cnt_reg   <= '0;
            realm_cnt_reg  <= '0;
            raw_cnt_reg    <= '0;
            err_reg        <= 1'b0;
            inst_seen_reg  <= 1'b0;
            realm_seen_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            esc_reg        <= esc_next;
            field_reg      <= field_next;
            name_cnt_reg   <= name_cnt_next;
            inst_cnt_reg   <= inst_cnt_next;
            realm_cnt_reg  <= realm_cnt_next;
            raw_cnt_reg    <= raw_cnt_next;
            err_reg        <= err_next;
            inst_seen_reg  <= inst_seen_next;
            realm_seen_reg <= realm_seen_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload loads only when a request is drained.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            char_valid_reg <= char_valid_next;
            field_tag_reg  <= field_tag_next;
            out_char_reg   <= out_char_next;
            done_reg       <= done_next;
            status_reg     <= status_next;
            inst_pres_reg  <= inst_pres_next;
            realm_pres_reg <= realm_pres_next;
        end
    end

endmodule

// File: hw/rtl/principal_name_splitter_unit.sv
// Top level of the principal name splitter: limit registers, front, queue and back.
// Depends on pns_pkg, pns_front, pns_queue and pns_back.
//
// The block takes one request per clock cycle while in_stall is low and returns
// exactly one result per request, in order. A request passes the front register, a
// four-entry queue and the back parser, which updates its flags and counters and
// loads the registered result; the queue absorbs output stalls until it is full,
// then the input stalls. The user must write limit registers through the cfg
// port only while no string is in flight; the block itself does not enforce it.
module principal_name_splitter_unit
    import pns_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] mode,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       char_valid,
    output logic [1:0] field_tag,
    output logic [7:0] out_char,
    output logic       done_res,
    output logic       status,
    output logic       instance_present,
    output logic       realm_present
);

    pns_limits_t limits_reg;
    pns_limits_t limits_next;
    pns_qstat_t  qstat;
    pns_item_t   push_item;
    pns_item_t   pop_item;
    logic        push;
    logic        pop;

    always_comb
    begin
        limits_next = limits_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_NAME_LIMIT:     limits_next.name_limit     = cfg_data;
                REG_INSTANCE_LIMIT: limits_next.instance_limit = cfg_data;
                REG_REALM_LIMIT:    limits_next.realm_limit    = cfg_data;
                REG_RAW_LIMIT:      limits_next.raw_limit      = cfg_data;
                default:            limits_next                = limits_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.name_limit     <= NAME_LIMIT_RST;
            limits_reg.instance_limit <= INSTANCE_LIMIT_RST;
            limits_reg.realm_limit    <= REALM_LIMIT_RST;
            limits_reg.raw_limit      <= RAW_LIMIT_RST;
        end
        else
        begin
            limits_reg <= limits_next;
        end
    end

    pns_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .in_byte   (in_byte),
        .qstat     (qstat),
        .push      (push),
        .push_item (push_item)
    );

    pns_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .qstat     (qstat)
    );

    pns_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .limits           (limits_reg),
        .qstat            (qstat),
        .pop_item         (pop_item),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .char_valid       (char_valid),
        .field_tag        (field_tag),
        .out_char         (out_char),
        .done_res         (done_res),
        .status           (status),
        .instance_present (instance_present),
        .realm_present    (realm_present)
    );

endmodule

// File: hw/rtl/pns_checker.sv
// Port-level checker for principal_name_splitter_unit, bound to the top level.
// Depends on pns_pkg and principal_name_splitter_unit_macros.svh.
`include "principal_name_splitter_unit_macros.svh"

module pns_checker
    import pns_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       char_valid,
    input logic [1:0] field_tag,
    input logic [7:0] out_char,
    input logic       done_res,
    input logic       status,
    input logic       instance_present,
    input logic       realm_present
);

    // Hold a stalled result and its payload.
    `PNS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(char_valid) && $stable(out_char) && $stable(done_res) && $stable(status), "stalled result changed")

    // Idle character slot reads as zero.
    `PNS_ASSERT_NOW(a_no_char_zero, clk, rst_n, out_valid && !char_valid, field_tag == FLD_NAME && out_char == 8'h00, "character fields set without a character")

    // End report fields are zero on a non-final result.
    `PNS_ASSERT_NOW(a_no_done_zero, clk, rst_n, out_valid && !done_res, !status && !instance_present && !realm_present, "end report set before the string end")

    // A realm always implies an instance was given, possibly empty.
    `PNS_ASSERT_NOW(a_realm_inst, clk, rst_n, out_valid && done_res && realm_present, instance_present, "realm present without instance")

endmodule

bind principal_name_splitter_unit pns_checker u_pns_checker (.*);
